// File: hw/rtl/xkbs_pkg.sv
// shared types, constants and the hex decode function of the key byte scorer
package xkbs_pkg;

    localparam int MAX_PERIOD  = 16;
    localparam int SCORE_BITS  = 20;
    localparam int PERIOD_W    = $clog2(MAX_PERIOD + 1);
    localparam int PHASE_W     = $clog2(MAX_PERIOD);
    localparam int CHAR_W      = 8;
    localparam int KEY_W       = 8;
    localparam int KEY_POS_W   = 4;
    localparam int BYTE_W      = CHAR_W + 4;
    localparam int WEIGHT_W    = 4;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 8;

    localparam logic [SCORE_BITS-1:0] SCORE_MAX = {SCORE_BITS{1'b1}};

    localparam logic [WEIGHT_W-1:0] W_LOWER = 4'd10;
    localparam logic [WEIGHT_W-1:0] W_UPPER = 4'd1;
    localparam logic [WEIGHT_W-1:0] W_SPACE = 4'd7;
    localparam logic [WEIGHT_W-1:0] W_NONE  = 4'd0;

    localparam logic [CHAR_W-1:0] CH_0     = 8'd48;
    localparam logic [CHAR_W-1:0] CH_9     = 8'd57;
    localparam logic [CHAR_W-1:0] CH_LO_A  = 8'd97;
    localparam logic [CHAR_W-1:0] CH_LO_F  = 8'd102;
    localparam logic [CHAR_W-1:0] CH_LO_Z  = 8'd122;
    localparam logic [CHAR_W-1:0] CH_UP_A  = 8'd65;
    localparam logic [CHAR_W-1:0] CH_UP_F  = 8'd70;
    localparam logic [CHAR_W-1:0] CH_UP_Z  = 8'd90;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'd32;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
    localparam logic [CHAR_W-1:0] CH_COMMA = 8'd44;
    localparam logic [CHAR_W-1:0] CH_DOT   = 8'd46;
    localparam logic [CHAR_W-1:0] OFS_LO   = 8'd87;
    localparam logic [CHAR_W-1:0] OFS_UP   = 8'd55;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CAND_KEY   = 2'd0,
        CFG_KEY_POS    = 2'd1,
        CFG_KEY_PERIOD = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [KEY_W-1:0]     cand_key;
        logic [KEY_POS_W-1:0] key_pos;
        logic [PERIOD_W-1:0]  period;
    } t_cfg;

    typedef struct packed {
        logic [WEIGHT_W-1:0] add;
        logic                ok;
    } t_class;

    // hex digit to value, anything else passes its own code
    function automatic logic [CHAR_W-1:0] decode_char(input logic [CHAR_W-1:0] ch);
        logic [CHAR_W-1:0] res;
        begin
            if (ch >= CH_0 && ch <= CH_9) begin
                res = ch - CH_0;
            end else if (ch >= CH_LO_A && ch <= CH_LO_F) begin
                res = ch - OFS_LO;
            end else if (ch >= CH_UP_A && ch <= CH_UP_F) begin
                res = ch - OFS_UP;
            end else begin
                res = ch;
            end
            return res;
        end
    endfunction

endpackage

// File: hw/rtl/xkbs_cfg.sv
// configuration registers and effective key period
module xkbs_cfg (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [xkbs_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [xkbs_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output xkbs_pkg::t_cfg                  o_cfg
);

    logic [xkbs_pkg::KEY_W-1:0]     r_cand_key;
    logic [xkbs_pkg::KEY_POS_W-1:0] r_key_pos;
    logic [xkbs_pkg::PERIOD_W-1:0]  r_key_period;
    logic [xkbs_pkg::PERIOD_W-1:0]  eff_period;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cand_key   <= '0;
            r_key_pos    <= '0;
            r_key_period <= xkbs_pkg::PERIOD_W'(1);
        end else if (i_cfg_valid) begin
            case (xkbs_pkg::t_cfg_idx'(i_cfg_index))
                xkbs_pkg::CFG_CAND_KEY: begin
                    r_cand_key <= i_cfg_data[xkbs_pkg::KEY_W-1:0];
                end
                xkbs_pkg::CFG_KEY_POS: begin
                    r_key_pos <= i_cfg_data[xkbs_pkg::KEY_POS_W-1:0];
                end
                xkbs_pkg::CFG_KEY_PERIOD: begin
                    r_key_period <= i_cfg_data[xkbs_pkg::PERIOD_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // zero acts as one, anything above the maximum acts as the maximum
    always_comb begin
        if (r_key_period == '0) begin
            eff_period = xkbs_pkg::PERIOD_W'(1);
        end else if (r_key_period > xkbs_pkg::PERIOD_W'(xkbs_pkg::MAX_PERIOD)) begin
            eff_period = xkbs_pkg::PERIOD_W'(xkbs_pkg::MAX_PERIOD);
        end else begin
            eff_period = r_key_period;
        end
    end

    assign o_cfg.cand_key = r_cand_key;
    assign o_cfg.key_pos  = r_key_pos;
    assign o_cfg.period   = eff_period;

endmodule

// File: hw/rtl/xkbs_classify.sv
// byte assembly, key xor and character class weight
module xkbs_classify (
    input  logic [xkbs_pkg::CHAR_W-1:0] i_first,
    input  logic [xkbs_pkg::CHAR_W-1:0] i_second,
    input  logic [xkbs_pkg::KEY_W-1:0]  i_key,
    output xkbs_pkg::t_class            o_class
);

    logic [xkbs_pkg::BYTE_W-1:0] pair;
    logic [xkbs_pkg::BYTE_W-1:0] plain;
    logic [xkbs_pkg::CHAR_W-1:0] low;

    // non-hex first nibbles reach into the upper bits
    assign pair  = {i_first, 4'b0000} | {4'b0000, i_second};
    assign plain = pair ^ {4'b0000, i_key};
    assign low   = plain[xkbs_pkg::CHAR_W-1:0];

    always_comb begin
        o_class.add = xkbs_pkg::W_NONE;
        o_class.ok  = 1'b1;
        if (plain[xkbs_pkg::BYTE_W-1:7] != '0) begin
            o_class.ok = 1'b0;
        end else if (low >= xkbs_pkg::CH_LO_A && low <= xkbs_pkg::CH_LO_Z) begin
            o_class.add = xkbs_pkg::W_LOWER;
        end else if (low >= xkbs_pkg::CH_UP_A && low <= xkbs_pkg::CH_UP_Z) begin
            o_class.add = xkbs_pkg::W_UPPER;
        end else if (low == xkbs_pkg::CH_SPACE
                     || (low >= xkbs_pkg::CH_TAB && low <= xkbs_pkg::CH_CR)) begin
            o_class.add = xkbs_pkg::W_SPACE;
        end else if (low != xkbs_pkg::CH_COMMA && low != xkbs_pkg::CH_DOT) begin
            o_class.ok = 1'b0;
        end
    end

endmodule

// File: hw/rtl/xor_key_byte_scorer_core.sv
// Scores one candidate key byte against a stream of hex ciphertext characters.
// Throughput is one character per cycle: a character is captured in an input
// register, and in the next cycle one pass of logic decodes it, pairs it with the
// pending nibble, xors the byte with the key and adds its weight to the running
// score, whose read-modify-write is the loop that sets the rate. The last character
// passes the input register, then the output register, before its result is valid.
// The output register holds the result while the next stream is already taken in;
// a stream's last character waits in the input register only while an earlier
// result is still stalled. Configuration writes are always ready and registered.
module xor_key_byte_scorer_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [xkbs_pkg::CHAR_W-1:0]       i_text_char,
    input  logic                              i_last,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [xkbs_pkg::SCORE_BITS-1:0]   o_score,
    output logic                              o_rejected,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [xkbs_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [xkbs_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    xkbs_pkg::t_cfg   cfg;
    xkbs_pkg::t_class cls;

    logic                              r_in_valid;
    logic [xkbs_pkg::CHAR_W-1:0]       r_in_char;
    logic                              r_in_last;

    logic [xkbs_pkg::CHAR_W-1:0]       r_first;
    logic                              r_have_first;
    logic [xkbs_pkg::PHASE_W-1:0]      r_phase;
    logic [xkbs_pkg::SCORE_BITS-1:0]   r_score;
    logic                              r_reject;

    logic [xkbs_pkg::CHAR_W-1:0]       n_first;
    logic                              n_have_first;
    logic [xkbs_pkg::PHASE_W-1:0]      n_phase;
    logic [xkbs_pkg::SCORE_BITS-1:0]   n_score;
    logic                              n_reject;

    logic                              r_out_valid;
    logic [xkbs_pkg::SCORE_BITS-1:0]   r_out_score;
    logic                              r_out_rejected;

    logic                              advance;
    logic                              in_accept;
    logic                              scoring;
    logic [xkbs_pkg::CHAR_W-1:0]       nib;
    logic [xkbs_pkg::PERIOD_W-1:0]     phase_inc;
    logic [xkbs_pkg::SCORE_BITS:0]     score_sum;

    xkbs_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    assign nib = xkbs_pkg::decode_char(r_in_char);

    xkbs_classify u_classify (
        .i_first  (r_first),
        .i_second (nib),
        .i_key    (cfg.cand_key),
        .o_class  (cls)
    );

    // a last item may only move on once the output register is free
    assign advance    = r_in_valid && !(r_in_last && r_out_valid && i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_accept  = i_in_valid && !o_in_stall;

    assign scoring   = r_have_first && (r_phase == cfg.key_pos);
    assign phase_inc = {1'b0, r_phase} + xkbs_pkg::PERIOD_W'(1);
    assign score_sum = {1'b0, r_score} + (xkbs_pkg::SCORE_BITS + 1)'(cls.add);

    always_comb begin
        n_first      = r_first;
        n_have_first = r_have_first;
        n_phase      = r_phase;
        n_score      = r_score;
        n_reject     = r_reject;
        if (!r_have_first) begin
            n_first      = nib;
            n_have_first = 1'b1;
        end else begin
            n_have_first = 1'b0;
            if (scoring) begin
                n_score  = score_sum[xkbs_pkg::SCORE_BITS] ? xkbs_pkg::SCORE_MAX
                                                           : score_sum[xkbs_pkg::SCORE_BITS-1:0];
                n_reject = r_reject || !cls.ok;
            end
            n_phase = (phase_inc >= cfg.period) ? '0 : phase_inc[xkbs_pkg::PHASE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_char <= i_text_char;
            r_in_last <= i_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first      <= '0;
            r_have_first <= 1'b0;
            r_phase      <= '0;
            r_score      <= '0;
            r_reject     <= 1'b0;
        end else if (advance) begin
            if (r_in_last) begin
                r_first      <= '0;
                r_have_first <= 1'b0;
                r_phase      <= '0;
                r_score      <= '0;
                r_reject     <= 1'b0;
            end else begin
                r_first      <= n_first;
                r_have_first <= n_have_first;
                r_phase      <= n_phase;
                r_score      <= n_score;
                r_reject     <= n_reject;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // a rejected stream reports a zero score
    always_ff @(posedge i_clk) begin
        if (advance && r_in_last) begin
            r_out_score    <= n_reject ? '0 : n_score;
            r_out_rejected <= n_reject;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_score     = r_out_score;
    assign o_rejected  = r_out_rejected;

`ifndef ASSERT_OFF
    a_reject_zero_score: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_rejected |-> o_score == '0)
        else $error("rejected result carries a nonzero score");

    a_last_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_in_last |=> o_out_valid)
        else $error("last item did not produce a result");

    a_last_clears_stream: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_in_last |=> r_phase == '0 && !r_have_first && r_score == '0
                                 && !r_reject)
        else $error("stream state not cleared after last item");

    a_pair_toggle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && !r_in_last |=> r_have_first != $past(r_have_first))
        else $error("pending nibble flag did not toggle");
`endif

endmodule

// File: verif/xor_key_byte_scorer_core_tb.sv
// testbench for the xor key byte scorer: streamed hex text checked against an in-bench score model
`timescale 1ns / 1ps

module xor_key_byte_scorer_core_tb;

    localparam int LIMIT_CYCLES = 2_000_000;
    localparam int RAND_TARGET  = 2000;
    localparam logic [xkbs_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    typedef struct packed {
        logic [xkbs_pkg::CHAR_W-1:0] ch;
        logic                        lst;
    } t_char_item;

    typedef struct packed {
        logic [xkbs_pkg::SCORE_BITS-1:0] score;
        logic                            rejected;
    } t_score_res;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_in_valid = 1'b0;
    logic                            o_in_stall;
    logic [xkbs_pkg::CHAR_W-1:0]     i_text_char = '0;
    logic                            i_last = 1'b0;
    logic                            o_out_valid;
    logic                            i_out_stall = 1'b0;
    logic [xkbs_pkg::SCORE_BITS-1:0] o_score;
    logic                            o_rejected;
    logic                            i_cfg_valid = 1'b0;
    logic                            o_cfg_ready;
    logic [xkbs_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [xkbs_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;

    xor_key_byte_scorer_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_text_char (i_text_char),
        .i_last      (i_last),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_score     (o_score),
        .o_rejected  (o_rejected),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    t_char_item char_q[$];
    t_score_res score_due_q[$];

    // register copies and stream state of the score model
    logic [xkbs_pkg::KEY_W-1:0]      key_cur = '0;
    logic [xkbs_pkg::KEY_POS_W-1:0]  pos_cur = '0;
    logic [4:0]                      period_cur = 5'd1;
    logic [xkbs_pkg::CHAR_W-1:0]     held_nib = '0;
    logic                            nib_held = 1'b0;
    logic [3:0]                      byte_phase = '0;
    logic [xkbs_pkg::SCORE_BITS-1:0] acc_score = '0;
    logic                            rej_seen = 1'b0;

    logic [xkbs_pkg::KEY_W-1:0]      gen_key = '0;
    bit                              quiet = 1'b0;
    int                              n_shown = 0;
    int                              n_taken = 0;
    int                              n_streams = 0;
    int                              n_results = 0;
    int                              n_cfg = 0;
    int                              n_errs = 0;
    int                              n_pushed = 0;
    int                              cycles = 0;
    int                              gap_left = 0;
    int                              stall_left = 0;

    function automatic logic [xkbs_pkg::CHAR_W-1:0] hex_value(
        input logic [xkbs_pkg::CHAR_W-1:0] ch);
        logic [xkbs_pkg::CHAR_W-1:0] v;
        v = ch;
        if (ch >= 8'd48 && ch <= 8'd57) v = ch - 8'd48;
        else if (ch >= 8'd97 && ch <= 8'd102) v = ch - 8'd87;
        else if (ch >= 8'd65 && ch <= 8'd70) v = ch - 8'd55;
        return v;
    endfunction

    task automatic score_char(input logic [xkbs_pkg::CHAR_W-1:0] ch, input logic lst);
        logic [xkbs_pkg::CHAR_W-1:0]   nib;
        logic [11:0]                   v;
        logic [7:0]                    lo;
        logic [xkbs_pkg::SCORE_BITS:0] sum;
        int                            per;
        int                            add;
        bit                            ok;
        t_score_res                    res;
        nib = hex_value(ch);
        if (!nib_held) begin
            held_nib = nib;
            nib_held = 1'b1;
        end else begin
            per = (period_cur == 5'd0) ? 1
                : ((int'(period_cur) > xkbs_pkg::MAX_PERIOD) ? xkbs_pkg::MAX_PERIOD
                                                              : int'(period_cur));
            // non-hex codes pass through, so the pair can be wider than a byte
            v = ({held_nib, 4'b0000} | {4'b0000, nib}) ^ {4'b0000, key_cur};
            lo = v[7:0];
            nib_held = 1'b0;
            if (byte_phase == pos_cur) begin
                add = 0;
                ok = 1'b1;
                if (v[11:7] != 5'd0) ok = 1'b0;
                else if (lo >= xkbs_pkg::CH_LO_A && lo <= xkbs_pkg::CH_LO_Z) add = 10;
                else if (lo >= xkbs_pkg::CH_UP_A && lo <= xkbs_pkg::CH_UP_Z) add = 1;
                else if (lo == xkbs_pkg::CH_SPACE
                         || (lo >= xkbs_pkg::CH_TAB && lo <= xkbs_pkg::CH_CR)) add = 7;
                else if (lo != xkbs_pkg::CH_COMMA && lo != xkbs_pkg::CH_DOT) ok = 1'b0;
                if (!ok) rej_seen = 1'b1;
                sum = {1'b0, acc_score} + (xkbs_pkg::SCORE_BITS + 1)'(add);
                acc_score = sum[xkbs_pkg::SCORE_BITS] ? {xkbs_pkg::SCORE_BITS{1'b1}}
                                                      : sum[xkbs_pkg::SCORE_BITS-1:0];
            end
            byte_phase = (int'(byte_phase) + 1 >= per) ? 4'd0 : byte_phase + 4'd1;
        end
        if (lst) begin
            res.score = rej_seen ? '0 : acc_score;
            res.rejected = rej_seen;
            score_due_q.push_back(res);
            held_nib = '0;
            nib_held = 1'b0;
            byte_phase = '0;
            acc_score = '0;
            rej_seen = 1'b0;
        end
    endtask

    // sender: item and register write accepted at the rising edge
    always @(posedge i_clk) begin
        if (i_cfg_valid && o_cfg_ready) begin
            n_cfg++;
            case (i_cfg_index)
                xkbs_pkg::CFG_CAND_KEY:   key_cur = i_cfg_data[xkbs_pkg::KEY_W-1:0];
                xkbs_pkg::CFG_KEY_POS:    pos_cur = i_cfg_data[xkbs_pkg::KEY_POS_W-1:0];
                xkbs_pkg::CFG_KEY_PERIOD: period_cur = i_cfg_data[4:0];
                default: ;
            endcase
        end
        if (i_in_valid && !o_in_stall) begin
            score_char(i_text_char, i_last);
            if (i_last) n_streams++;
            void'(char_q.pop_front());
            n_taken++;
        end
    end

    // sender: new item or idle burst at the falling edge
    always @(negedge i_clk) begin
        if (i_in_valid && n_taken != n_shown) begin
            // stalled item holds
        end else if (gap_left > 0) begin
            gap_left--;
            i_in_valid <= 1'b0;
        end else if (char_q.size() == 0) begin
            i_in_valid <= 1'b0;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            gap_left = int'($urandom_range(0, 9));
            i_in_valid <= 1'b0;
        end else begin
            i_in_valid <= 1'b1;
            i_text_char <= char_q[0].ch;
            i_last <= char_q[0].lst;
            n_shown++;
        end
    end

    // receiver stall bursts
    always @(negedge i_clk) begin
        if (quiet) begin
            stall_left = 0;
            i_out_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else if ($urandom_range(0, 5) == 0) begin
            stall_left = int'($urandom_range(0, 9));
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        t_score_res want;
        if (o_out_valid && !i_out_stall) begin
            n_results++;
            if (score_due_q.size() == 0) begin
                n_errs++;
                $display("%0t: result with none pending: score %0d rejected %0b",
                         $time, o_score, o_rejected);
            end else begin
                want = score_due_q.pop_front();
                if (o_score !== want.score) begin
                    n_errs++;
                    $display("%0t: score expected %0d actual %0d",
                             $time, want.score, o_score);
                end
                if (o_rejected !== want.rejected) begin
                    n_errs++;
                    $display("%0t: rejected expected %0b actual %0b",
                             $time, want.rejected, o_rejected);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("%0t: timeout, %0d results still pending", $time, score_due_q.size());
            $display("FAIL xor_key_byte_scorer_core");
            $finish;
        end
    end

    task automatic push_char(input logic [xkbs_pkg::CHAR_W-1:0] ch, input logic lst);
        t_char_item it;
        it.ch = ch;
        it.lst = lst;
        char_q.push_back(it);
        n_pushed++;
    endtask

    function automatic logic [xkbs_pkg::CHAR_W-1:0] hex_char(input logic [3:0] n,
                                                             input bit clean);
        logic [xkbs_pkg::CHAR_W-1:0] c;
        if (n < 4'd10) c = xkbs_pkg::CH_0 + {4'b0000, n};
        else c = ($urandom_range(0, 1) == 1 ? xkbs_pkg::CH_UP_A : xkbs_pkg::CH_LO_A)
                 + {4'b0000, n} - 8'd10;
        if (!clean && $urandom_range(0, 29) == 0) c = 8'($urandom_range(0, 255));
        return c;
    endfunction

    function automatic logic [7:0] pick_plain(input bit clean);
        int r;
        logic [7:0] p;
        r = int'($urandom_range(0, clean ? 17 : 19));
        if (r <= 9) p = 8'($urandom_range(97, 122));
        else if (r <= 12) p = 8'($urandom_range(65, 90));
        else if (r <= 14) p = xkbs_pkg::CH_SPACE;
        else if (r == 15) p = 8'($urandom_range(9, 13));
        else if (r == 16) p = xkbs_pkg::CH_COMMA;
        else if (r == 17) p = xkbs_pkg::CH_DOT;
        else p = 8'($urandom_range(0, 255));
        return p;
    endfunction

    // bytes of plain text under the current key, hex encoded
    task automatic push_stream(input int n_bytes, input bit odd_tail, input bit close_it,
                               input bit clean);
        logic [7:0] cb;
        int k;
        for (k = 0; k < n_bytes; k++) begin
            cb = pick_plain(clean) ^ gen_key;
            push_char(hex_char(cb[7:4], clean), 1'b0);
            push_char(hex_char(cb[3:0], clean), close_it && !odd_tail && k == n_bytes - 1);
        end
        if (close_it && (odd_tail || n_bytes == 0))
            push_char(hex_char(4'($urandom_range(0, 15)), clean), 1'b1);
    endtask

    task automatic write_reg(input logic [xkbs_pkg::CFG_IDX_W-1:0] idx,
                             input logic [xkbs_pkg::CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (idx == xkbs_pkg::CFG_CAND_KEY) gen_key = data;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // sender pauses until every result is back and the pipe is empty
    task automatic drain();
        while (char_q.size() != 0 || score_due_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    initial begin
        string txt;
        int i;
        int rand_items;
        int n_str;
        int per_data;
        int eff;
        int pos_data;
        int r;
        txt = "6141202c2E0a7A5a";
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // every class of letter, whitespace, comma and period under reset settings
        for (i = 0; i < txt.len(); i++) push_char(txt[i], i == txt.len() - 1);
        // lone trailing character, then a pair followed by a non-hex trailing one
        push_char("7", 1'b1);
        push_char("6", 1'b0);
        push_char("1", 1'b0);
        push_char("g", 1'b1);
        // raw codes form a wide byte that rejects
        push_char(8'hFF, 1'b0);
        push_char(8'h00, 1'b1);
        drain();

        // all-ones data: period 31 acts as the maximum, position 15
        write_reg(xkbs_pkg::CFG_CAND_KEY, 8'hFF);
        write_reg(xkbs_pkg::CFG_KEY_POS, 8'hFF);
        write_reg(xkbs_pkg::CFG_KEY_PERIOD, 8'hFF);
        write_reg(CFG_SPARE, 8'hAA);
        push_stream(16, 1'b0, 1'b1, 1'b1);
        push_stream(33, 1'b1, 1'b1, 1'b1);
        drain();
        // period zero acts as one
        write_reg(xkbs_pkg::CFG_KEY_PERIOD, 8'd0);
        write_reg(xkbs_pkg::CFG_KEY_POS, 8'd0);
        write_reg(xkbs_pkg::CFG_CAND_KEY, 8'h00);
        push_stream(6, 1'b0, 1'b1, 1'b1);
        drain();
        // position beyond the period never scores
        write_reg(xkbs_pkg::CFG_KEY_PERIOD, 8'd4);
        write_reg(xkbs_pkg::CFG_KEY_POS, 8'd9);
        push_stream(8, 1'b0, 1'b1, 1'b0);
        drain();
        // period shrinks in the middle of a stream
        write_reg(xkbs_pkg::CFG_KEY_PERIOD, 8'd16);
        write_reg(xkbs_pkg::CFG_KEY_POS, 8'd5);
        push_stream(10, 1'b0, 1'b0, 1'b1);
        drain();
        write_reg(xkbs_pkg::CFG_KEY_PERIOD, 8'd3);
        write_reg(xkbs_pkg::CFG_KEY_POS, 8'd2);
        push_stream(6, 1'b0, 1'b1, 1'b1);
        drain();

        rand_items = 0;
        while (rand_items < RAND_TARGET) begin
            r = int'($urandom_range(0, 5));
            case (r)
                0: per_data = 0;
                1: per_data = 1;
                2: per_data = 16;
                3: per_data = 255;
                4: per_data = int'($urandom_range(1, 16));
                default: per_data = int'($urandom_range(0, 255));
            endcase
            eff = per_data & 31;
            if (eff == 0) eff = 1;
            if (eff > xkbs_pkg::MAX_PERIOD) eff = xkbs_pkg::MAX_PERIOD;
            if ($urandom_range(0, 4) == 0) pos_data = int'($urandom_range(0, 255));
            else pos_data = int'($urandom_range(0, eff - 1) | ($urandom_range(0, 15) << 4));
            write_reg(xkbs_pkg::CFG_KEY_PERIOD, 8'(per_data));
            write_reg(xkbs_pkg::CFG_KEY_POS, 8'(pos_data));
            r = int'($urandom_range(0, 7));
            write_reg(xkbs_pkg::CFG_CAND_KEY,
                      (r == 0) ? 8'h00 : ((r == 1) ? 8'hFF : 8'($urandom_range(0, 255))));
            n_pushed = 0;
            n_str = int'($urandom_range(1, 6));
            for (i = 0; i < n_str; i++)
                push_stream(($urandom_range(0, 9) == 0) ? int'($urandom_range(30, 60))
                                                        : int'($urandom_range(0, 20)),
                            $urandom_range(0, 2) == 0,
                            !(i == n_str - 1 && $urandom_range(0, 3) == 0),
                            $urandom_range(0, 9) < 7);
            rand_items += n_pushed;
            drain();
        end

        // closing stretch without idling on either side
        quiet = 1'b1;
        write_reg(xkbs_pkg::CFG_KEY_PERIOD, 8'd2);
        write_reg(xkbs_pkg::CFG_KEY_POS, 8'd1);
        write_reg(xkbs_pkg::CFG_CAND_KEY, 8'($urandom_range(0, 255)));
        for (i = 0; i < 4; i++)
            push_stream(int'($urandom_range(0, 20)), $urandom_range(0, 1) == 1, 1'b1, 1'b1);
        drain();
        repeat (10) @(posedge i_clk);

        $display("run covered %0d characters in %0d streams, %0d results, %0d register writes",
                 n_taken, n_streams, n_results, n_cfg);
        $display("including odd tails, rejects, out of range registers and a period change");
        if (n_errs == 0) begin
            $display("PASS xor_key_byte_scorer_core");
        end else begin
            $display("%0d mismatches", n_errs);
            $display("FAIL xor_key_byte_scorer_core");
        end
        $finish;
    end

endmodule
